### hw/rtl/clrm_pkg.sv
`timescale 1ns / 1ps

package clrm_pkg;

    // code store and record frame geometry
    localparam int MAX_CODE     = 12;
    localparam int RECORD_BYTES = 16;
    localparam int LEN_W        = 4;
    localparam int IDX_W        = 5;
    localparam int SLOT_W       = 4;

    // frame markers and blank code byte
    localparam logic [7:0] HEADER_MARK  = 8'h5a;
    localparam logic [7:0] TRAILER_MARK = 8'ha5;
    localparam logic [7:0] BLANK_BYTE   = 8'hff;
    localparam logic [IDX_W-1:0] INDEX_CAP = 5'd31;

    // command codes on the input port
    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_KEY    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // verdict kinds on the result port
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_KEY    = 1'b1;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_KEY    = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
    } op_item_t;

    typedef struct packed {
        logic             kind;
        logic             ok;
        logic [LEN_W-1:0] code_length;
    } res_item_t;

endpackage

### hw/rtl/code_lock_record_and_match.sv
`timescale 1ns / 1ps
// Code lock with stored-record check and sliding key match.
// Input side is a queue: drive cmd, data_byte and last with push; the item is
// taken on a clock edge where push is high and full is low. cmd 0 carries a
// stored record byte, cmd 1 an entered key byte, cmd 2 clears the stored code;
// cmd 3 is taken and dropped.
// Result side is a queue: while empty is low the oldest verdict sits on kind,
// ok and code_length; it is taken on an edge where pop is high.
// A verdict comes only for a last record byte or a last key byte. The item
// passes through the front queue to the execute stage, which runs it once the
// result queue has room and writes its verdict into the result queue.
// One item per cycle is executed unless the result queue is full; a record
// byte is checked or the whole 12-byte key window matched to the stored code.
// If pop stays low the two-entry result queue fills, the execute stage holds,
// and full rises once the two-entry input queue is also taken up.
// Reset empties both queues, blanks the stored code to 0xff bytes with length
// 0 and restarts any record or key entry in progress; no clearing pass.

module code_lock_record_and_match
    import clrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic       kind,
    output logic       ok,
    output logic [3:0] code_length
);

    logic      q_valid;
    op_item_t  q_item;
    logic      q_pop;
    logic      res_full;
    logic      res_push;
    res_item_t res_item;

    // accept and classify
    clrm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .data_byte (data_byte),
        .last      (last),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // record check and key match
    clrm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_item (res_item)
    );

    // verdict queue
    clrm_out_q u_out_q (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_push    (res_push),
        .res_item    (res_item),
        .res_full    (res_full),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .ok          (ok),
        .code_length (code_length)
    );

endmodule

### hw/rtl/clrm_front.sv
`timescale 1ns / 1ps

module clrm_front
    import clrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] cmd,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       q_valid,
    output op_item_t   q_item,
    input  logic       q_pop
);

    op_item_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    op_item_t   cls_item;
    logic       keep;
    logic       wr_en;
    logic       rd_en;

    // classify the incoming command, unused codes are dropped
    always_comb
    begin
        keep          = 1'b1;
        cls_item.op   = OP_CLEAR;
        cls_item.data = data_byte;
        cls_item.last = last;
        case (cmd)
            CMD_RECORD: cls_item.op = OP_RECORD;
            CMD_KEY:    cls_item.op = OP_KEY;
            CMD_CLEAR:  cls_item.op = OP_CLEAR;
            default:    keep = 1'b0;
        endcase
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign wr_en   = push && !full && keep;
    assign rd_en   = q_pop && q_valid;

    // two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

### hw/rtl/clrm_back.sv
`timescale 1ns / 1ps

module clrm_back
    import clrm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  op_item_t  q_item,
    output logic      q_pop,
    input  logic      res_full,
    output logic      res_push,
    output res_item_t res_item
);

    logic [7:0]       stored_code_reg  [MAX_CODE];
    logic [7:0]       stored_code_next [MAX_CODE];
    logic [LEN_W-1:0] stored_length_reg, stored_length_next;
    logic [7:0]       staging_code_reg [MAX_CODE];
    logic [IDX_W-1:0] record_index_reg, record_index_next;
    logic [7:0]       record_length_reg, record_length_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic             record_good_reg, record_good_next;
    logic [7:0]       key_window_reg  [MAX_CODE];
    logic [7:0]       key_window_next [MAX_CODE];
    logic [LEN_W-1:0] key_count_reg, key_count_next;
    logic             entry_matched_reg, entry_matched_next;

    logic                  fire;
    logic                  is_record;
    logic                  is_key;
    logic                  is_clear;
    logic [7:0]            b;
    logic [IDX_W-1:0]      slot_off;
    logic                  stage_we;
    logic [SLOT_W-1:0]     stage_slot;
    logic                  rec_good;
    logic [7:0]            rec_len;
    logic                  rec_ok;
    logic [LEN_W-1:0]      count_new;
    logic [(1<<LEN_W)-1:0] len_match;
    logic                  hit;
    logic                  key_ok;

    assign fire      = q_valid && !res_full;
    assign q_pop     = fire;
    assign b         = q_item.data;
    assign is_record = fire && (q_item.op == OP_RECORD);
    assign is_key    = fire && (q_item.op == OP_KEY);
    assign is_clear  = fire && (q_item.op == OP_CLEAR);
    assign slot_off  = record_index_reg - 5'd2;

    // record frame check, one byte per item
    always_comb
    begin
        rec_good   = record_good_reg;
        rec_len    = record_length_reg;
        stage_we   = 1'b0;
        stage_slot = slot_off[SLOT_W-1:0];
        running_sum_next = running_sum_reg;
        if (record_index_reg >= IDX_W'(RECORD_BYTES))
        begin
            rec_good = 1'b0;
        end
        else if (record_index_reg == 5'd0)
        begin
            if (b != HEADER_MARK)
            begin
                rec_good = 1'b0;
            end
        end
        else if (record_index_reg == 5'd1)
        begin
            rec_len = b;
            if (b > 8'(MAX_CODE))
            begin
                rec_good = 1'b0;
            end
        end
        else if (9'(record_index_reg) < 9'(record_length_reg) + 9'd2)
        begin
            stage_we         = (slot_off < IDX_W'(MAX_CODE));
            running_sum_next = running_sum_reg + b;
        end
        else if (9'(record_index_reg) == 9'(record_length_reg) + 9'd2)
        begin
            if (b != running_sum_reg)
            begin
                rec_good = 1'b0;
            end
        end
        else if (9'(record_index_reg) == 9'(record_length_reg) + 9'd3)
        begin
            if (b != TRAILER_MARK)
            begin
                rec_good = 1'b0;
            end
        end
        // short or overlong length at the closing byte
        rec_ok = rec_good && (rec_len <= 8'(MAX_CODE))
                 && !(9'(record_index_reg) < 9'(rec_len) + 9'd3);
    end

    // key window shift and parallel compare against the stored code
    always_comb
    begin
        for (int k = 0; k < MAX_CODE - 1; k++)
        begin
            key_window_next[k] = key_window_reg[k+1];
        end
        key_window_next[MAX_CODE-1] = b;
        count_new = (key_count_reg < LEN_W'(MAX_CODE)) ? key_count_reg + 4'd1
                                                       : key_count_reg;
        len_match    = '0;
        len_match[0] = 1'b1;
        for (int l = 1; l <= MAX_CODE; l++)
        begin
            len_match[l] = 1'b1;
            for (int k = 0; k < MAX_CODE; k++)
            begin
                if (k < l)
                begin
                    if (key_window_next[MAX_CODE-l+k] != stored_code_reg[k])
                    begin
                        len_match[l] = 1'b0;
                    end
                end
            end
        end
        hit    = len_match[stored_length_reg] && (count_new >= stored_length_reg);
        key_ok = entry_matched_reg || hit;
    end

    // next state of everything touched by the current item
    always_comb
    begin
        stored_code_next   = stored_code_reg;
        stored_length_next = stored_length_reg;
        record_index_next  = record_index_reg;
        record_length_next = record_length_reg;
        record_good_next   = record_good_reg;
        key_count_next     = key_count_reg;
        entry_matched_next = entry_matched_reg;
        res_push           = 1'b0;
        res_item.kind      = KIND_RECORD;
        res_item.ok        = 1'b0;
        if (is_record)
        begin
            record_index_next  = (record_index_reg < INDEX_CAP) ? record_index_reg + 5'd1
                                                                : record_index_reg;
            record_length_next = rec_len;
            record_good_next   = rec_good;
            if (q_item.last)
            begin
                if (rec_ok)
                begin
                    for (int k = 0; k < MAX_CODE; k++)
                    begin
                        if (LEN_W'(k) < rec_len[LEN_W-1:0])
                        begin
                            stored_code_next[k] = staging_code_reg[k];
                        end
                    end
                    stored_length_next = rec_len[LEN_W-1:0];
                end
                else
                begin
                    for (int k = 0; k < MAX_CODE; k++)
                    begin
                        stored_code_next[k] = BLANK_BYTE;
                    end
                    stored_length_next = '0;
                end
                record_index_next  = '0;
                record_length_next = '0;
                record_good_next   = 1'b1;
                res_push           = 1'b1;
                res_item.kind      = KIND_RECORD;
                res_item.ok        = rec_ok;
            end
        end
        else if (is_key)
        begin
            key_count_next     = q_item.last ? '0 : count_new;
            entry_matched_next = q_item.last ? 1'b0 : key_ok;
            if (q_item.last)
            begin
                res_push      = 1'b1;
                res_item.kind = KIND_KEY;
                res_item.ok   = key_ok;
            end
        end
        else if (is_clear)
        begin
            for (int k = 0; k < MAX_CODE; k++)
            begin
                stored_code_next[k] = BLANK_BYTE;
            end
            stored_length_next = '0;
        end
        res_item.code_length = stored_length_next;
    end

    // control and stored code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CODE; k++)
            begin
                stored_code_reg[k] <= BLANK_BYTE;
            end
            stored_length_reg <= '0;
            record_index_reg  <= '0;
            record_length_reg <= '0;
            running_sum_reg   <= '0;
            record_good_reg   <= 1'b1;
            key_count_reg     <= '0;
            entry_matched_reg <= 1'b0;
        end
        else
        begin
            stored_code_reg   <= stored_code_next;
            stored_length_reg <= stored_length_next;
            record_index_reg  <= record_index_next;
            record_length_reg <= record_length_next;
            key_count_reg     <= key_count_next;
            entry_matched_reg <= entry_matched_next;
            record_good_reg   <= record_good_next;
            if (is_record)
            begin
                running_sum_reg <= q_item.last ? 8'd0 : running_sum_next;
            end
        end
    end

    // staging bytes and key window, no reset needed
    always_ff @(posedge clk)
    begin
        if (is_record && stage_we)
        begin
            staging_code_reg[stage_slot] <= b;
        end
        if (is_key)
        begin
            key_window_reg <= key_window_next;
        end
    end

endmodule

### hw/rtl/clrm_out_q.sv
`timescale 1ns / 1ps

module clrm_out_q
    import clrm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_push,
    input  res_item_t  res_item,
    output logic       res_full,
    output logic       empty,
    input  logic       pop,
    output logic       kind,
    output logic       ok,
    output logic [3:0] code_length
);

    res_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr_en;
    logic       rd_en;
    res_item_t  head;

    assign res_full    = (count_reg == 2'd2);
    assign empty       = (count_reg == 2'd0);
    assign wr_en       = res_push && !res_full;
    assign rd_en       = pop && !empty;
    assign head        = slot_reg[rd_ptr_reg];
    assign kind        = head.kind;
    assign ok          = head.ok;
    assign code_length = head.code_length;

    // two-entry result queue pointers
    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= res_item;
        end
    end

endmodule

### hw/rtl/clrm_checker.sv
`timescale 1ns / 1ps

module clrm_checker
    import clrm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       kind,
    input logic       ok,
    input logic [3:0] code_length
);

    // reset leaves both queues open and empty
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queues not cleared during reset");

    // a rejected record always blanks the code
    a_bad_record_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind == KIND_RECORD && !ok) |-> (code_length == 4'd0))
        else $error("failed record left a nonzero code length");

    // stored length never exceeds the code store
    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (code_length <= 4'(MAX_CODE)))
        else $error("code length out of range");

    // an empty block with a clear input queue cannot report full next cycle
    a_full_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !full) |=> !full)
        else $error("full rose without a backed-up result queue");

    // a waiting verdict holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(ok)
                               && $stable(code_length)))
        else $error("waiting verdict changed");

endmodule

bind code_lock_record_and_match clrm_checker u_clrm_checker (.*);
